[rtl/trsm_pkg.sv]
// Package with the shared types and codes of the TCP receive state machine.
package trsm_pkg;

    // Connection states, in the encoding used on the new_state and conn_state_out fields.
    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_SENT    = 4'd2,
        ST_SYN_RECV    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_CLOSE_WAIT  = 4'd5,
        ST_LAST_ACK    = 4'd6,
        ST_FIN_WAIT_1  = 4'd7,
        ST_FIN_WAIT_2  = 4'd8,
        ST_CLOSING     = 4'd9,
        ST_TIME_WAIT   = 4'd10
    } t_conn_state;

    // Control packet requested from the transmit side.
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_RST   = 2'd2,
        ACT_SPAWN = 2'd3
    } t_action;

    // Request kinds.
    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // TCP flag masks.
    localparam logic [5:0] FLAG_FIN = 6'h01;
    localparam logic [5:0] FLAG_SYN = 6'h02;
    localparam logic [5:0] FLAG_RST = 6'h04;
    localparam logic [5:0] FLAG_ACK = 6'h10;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  new_state;
        logic [5:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_seq_end;
        logic [31:0] seg_ack;
        logic [15:0] peer_window;
        logic [15:0] payload_len;
        logic [31:0] snd_next;
        logic [31:0] init_seq;
    } t_req;

    typedef struct packed {
        logic [1:0]  send_action;
        logic [3:0]  conn_state_out;
        logic [31:0] rcv_next_out;
        logic [31:0] snd_unack_out;
        logic [15:0] send_window_out;
        logic        deliver_payload;
        logic        in_order;
        logic        wake_send;
        logic        wake_connect;
        logic        wake_accept;
        logic        start_timewait;
        logic        drop_conn;
    } t_rsp;

    // Connection registers that carry over from one transaction to the next.
    typedef struct packed {
        t_conn_state state;
        logic [31:0] rcv_next;
        logic [31:0] snd_unack;
        logic [15:0] send_window;
    } t_conn_regs;

endpackage

[rtl/trsm_if.sv]
// Valid/ready channel interfaces for requests and results.
interface trsm_req_if;
    logic            valid;
    logic            ready;
    trsm_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface trsm_rsp_if;
    logic            valid;
    logic            ready;
    trsm_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/trsm_core.sv]
// Combinational decision logic for one request against the connection registers.
module trsm_core (
    input  trsm_pkg::t_req       i_req,
    input  trsm_pkg::t_conn_regs i_regs,
    output trsm_pkg::t_conn_regs o_regs_next,
    output trsm_pkg::t_rsp       o_rsp
);

    logic        w_in_order;
    logic        w_ack_le;
    logic        w_ack_eq;
    logic        w_fin;
    logic        w_syn;
    logic        w_rst;
    logic        w_ack;
    logic        w_spawn;
    logic [31:0] w_ack_dist;
    trsm_pkg::t_action w_action;

    assign w_fin      = |(i_req.seg_flags & trsm_pkg::FLAG_FIN);
    assign w_syn      = |(i_req.seg_flags & trsm_pkg::FLAG_SYN);
    assign w_rst      = |(i_req.seg_flags & trsm_pkg::FLAG_RST);
    assign w_ack      = |(i_req.seg_flags & trsm_pkg::FLAG_ACK);
    assign w_in_order = (i_req.seg_seq == i_regs.rcv_next) && (i_regs.rcv_next != 32'd0);
    // The ack is within snd_next when the wrapped distance is not negative.
    assign w_ack_dist = i_req.snd_next - i_req.seg_ack;
    assign w_ack_le   = ~w_ack_dist[31];
    assign w_ack_eq   = (i_req.seg_ack == i_req.snd_next);

    always_comb begin
        o_regs_next = i_regs;
        w_action    = trsm_pkg::ACT_NONE;
        w_spawn     = 1'b0;
        o_rsp       = '0;

        if (i_req.req_type == trsm_pkg::REQ_COMMAND) begin
            if (i_req.new_state <= trsm_pkg::ST_TIME_WAIT) begin
                o_regs_next.state = trsm_pkg::t_conn_state'(i_req.new_state);
            end
        end else begin
            // Common bookkeeping for every segment.
            o_rsp.in_order = w_in_order;
            if (w_in_order || (i_regs.rcv_next == 32'd0)) begin
                o_regs_next.rcv_next = i_req.seg_seq_end;
            end
            o_regs_next.snd_unack = i_req.seg_ack;
            if (w_ack_le) begin
                o_rsp.wake_send         = (i_regs.send_window == 16'd0);
                o_regs_next.send_window = i_req.peer_window;
            end

            if (w_rst) begin
                o_regs_next.state = trsm_pkg::ST_CLOSED;
                o_rsp.drop_conn   = 1'b1;
            end else begin
                case (i_regs.state)
                    trsm_pkg::ST_CLOSED: begin
                        w_action = trsm_pkg::ACT_RST;
                    end
                    trsm_pkg::ST_LISTEN: begin
                        if (w_syn) begin
                            w_action = trsm_pkg::ACT_SPAWN;
                            w_spawn  = 1'b1;
                        end else begin
                            w_action = trsm_pkg::ACT_RST;
                        end
                    end
                    trsm_pkg::ST_SYN_SENT: begin
                        if (w_syn && w_ack) begin
                            o_regs_next.rcv_next    = i_req.seg_seq_end;
                            o_regs_next.send_window = i_req.peer_window;
                            o_regs_next.state       = trsm_pkg::ST_ESTABLISHED;
                            w_action                = trsm_pkg::ACT_ACK;
                            o_rsp.wake_connect      = 1'b1;
                        end else begin
                            w_action = trsm_pkg::ACT_RST;
                        end
                    end
                    trsm_pkg::ST_SYN_RECV: begin
                        o_regs_next.send_window = i_req.peer_window;
                        o_regs_next.state       = trsm_pkg::ST_ESTABLISHED;
                        o_rsp.wake_accept       = 1'b1;
                    end
                    trsm_pkg::ST_FIN_WAIT_1: begin
                        if (w_ack_eq) begin
                            o_regs_next.state = trsm_pkg::ST_FIN_WAIT_2;
                        end
                    end
                    trsm_pkg::ST_FIN_WAIT_2: begin
                        if (w_fin && w_ack_eq) begin
                            o_regs_next.state    = trsm_pkg::ST_TIME_WAIT;
                            o_rsp.start_timewait = 1'b1;
                            w_action             = trsm_pkg::ACT_ACK;
                        end
                    end
                    trsm_pkg::ST_CLOSE_WAIT: begin
                        if (w_fin) begin
                            w_action = trsm_pkg::ACT_ACK;
                        end
                    end
                    trsm_pkg::ST_TIME_WAIT: begin
                        if (i_req.seg_flags == (trsm_pkg::FLAG_FIN | trsm_pkg::FLAG_ACK)) begin
                            w_action = trsm_pkg::ACT_ACK;
                        end
                    end
                    trsm_pkg::ST_LAST_ACK: begin
                        if ((i_req.seg_flags == trsm_pkg::FLAG_ACK) && w_ack_eq) begin
                            o_regs_next.state = trsm_pkg::ST_CLOSED;
                        end
                    end
                    trsm_pkg::ST_ESTABLISHED: begin
                        if (w_fin && w_ack_eq) begin
                            o_regs_next.state = trsm_pkg::ST_CLOSE_WAIT;
                            w_action          = trsm_pkg::ACT_ACK;
                        end else if (i_req.payload_len != 16'd0) begin
                            o_rsp.deliver_payload = 1'b1;
                            w_action              = trsm_pkg::ACT_ACK;
                        end else if (i_req.seg_flags == trsm_pkg::FLAG_ACK) begin
                            w_action = trsm_pkg::ACT_NONE;
                        end else begin
                            w_action = trsm_pkg::ACT_ACK;
                        end
                    end
                    default: begin
                        // Closing and unused codes only do the common bookkeeping.
                        w_action = trsm_pkg::ACT_NONE;
                    end
                endcase
            end
        end

        o_rsp.send_action     = w_action;
        o_rsp.conn_state_out  = o_regs_next.state;
        o_rsp.rcv_next_out    = w_spawn ? i_req.seg_seq_end : o_regs_next.rcv_next;
        o_rsp.snd_unack_out   = o_regs_next.snd_unack;
        o_rsp.send_window_out = o_regs_next.send_window;
    end

endmodule

[rtl/tcp_receive_state_machine.sv]
// Top level of the TCP receive state machine: request register, decision, result register.
// A request moves through both registers in turn. Throughput: one transaction per cycle
// while o_rsp.ready holds; the connection registers are read and rewritten by a single
// combinational pass, so each request sees the state left by the one before.
// Reset: i_rst_n is synchronous and active low; it empties both pipeline registers and
// returns the connection to closed with rcv_next, snd_unack and send_window at zero.
module tcp_receive_state_machine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    trsm_req_if.sink        i_req,
    trsm_rsp_if.source      o_rsp
);

    // Request register. It accepts a new transaction when it is empty or when its
    // contents move on to the result register in the same cycle.
    logic                  r_in_valid;
    trsm_pkg::t_req        r_in;

    // Result register. It frees up when empty or when the sink takes the result; a waiting
    // result holds the request register, which then stalls the input once it is full.
    logic                  r_out_valid;
    trsm_pkg::t_rsp        r_out;

    // Connection registers carried from one segment to the next.
    trsm_pkg::t_conn_regs  r_regs;

    trsm_pkg::t_conn_regs  n_regs;
    trsm_pkg::t_rsp        w_rsp;
    logic                  w_adv;
    logic                  w_take;
    logic                  w_update;

    assign w_adv       = ~r_out_valid | o_rsp.ready;
    assign i_req.ready = ~r_in_valid | w_adv;
    assign w_take      = i_req.valid & i_req.ready;
    // The connection registers change exactly when a request moves into the result register.
    assign w_update    = w_adv & r_in_valid;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    trsm_core u_core (
        .i_req       (r_in),
        .i_regs      (r_regs),
        .o_regs_next (n_regs),
        .o_rsp       (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.state       <= trsm_pkg::ST_CLOSED;
            r_regs.rcv_next    <= 32'd0;
            r_regs.snd_unack   <= 32'd0;
            r_regs.send_window <= 16'd0;
        end else if (w_update) begin
            r_regs <= n_regs;
        end
    end

`ifndef SYNTHESIS
    // A received reset always leaves the connection closed.
    a_drop_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.drop_conn) |-> (r_out.conn_state_out == trsm_pkg::ST_CLOSED))
        else $error("drop_conn reported without closed state");

    // A spawned child leaves the parent listening.
    a_spawn_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.send_action == trsm_pkg::ACT_SPAWN))
        |-> (r_out.conn_state_out == trsm_pkg::ST_LISTEN))
        else $error("spawn reported while parent not listening");

    // A completed open always lands in established.
    a_open_established: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.wake_connect || r_out.wake_accept))
        |-> (r_out.conn_state_out == trsm_pkg::ST_ESTABLISHED))
        else $error("open completion without established state");

    // Connection registers only change when a transaction passes through the decision.
    a_regs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_update |=> $stable(r_regs))
        else $error("connection registers changed without a transaction");

    // The reported state matches the state register after the update.
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_update |=> (r_out.conn_state_out == r_regs.state))
        else $error("reported state differs from state register");
`endif

endmodule

[tb/trsm_checker.sv]
// Checker for the TCP receive state machine: predicts each result and compares it.
module trsm_checker
    import trsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    trsm_req_if  i_req,
    trsm_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the connection registers.
    t_conn_state conn_st;
    logic [31:0] rcv_nxt;
    logic [31:0] snd_una;
    logic [15:0] snd_wnd;

    t_rsp expected_q[$];
    int   fail_total = 0;

    // Applies one request to the shadow registers and returns the result it should produce.
    function automatic t_rsp predict_result(input t_req r);
        t_rsp        p;
        logic [31:0] ack_gap;
        logic        spawned;
        p = '0;
        spawned = 1'b0;
        if (r.req_type == REQ_COMMAND) begin
            if (r.new_state <= ST_TIME_WAIT) begin
                conn_st = t_conn_state'(r.new_state);
            end
        end else begin
            // A zero rcv_next means the peer's sequence is not known yet.
            if (r.seg_seq == rcv_nxt && rcv_nxt != 32'd0) begin
                p.in_order = 1'b1;
                rcv_nxt = r.seg_seq_end;
            end else if (rcv_nxt == 32'd0) begin
                rcv_nxt = r.seg_seq_end;
            end
            snd_una = r.seg_ack;
            ack_gap = r.snd_next - r.seg_ack;
            if (!ack_gap[31]) begin
                if (snd_wnd == 16'd0) begin
                    p.wake_send = 1'b1;
                end
                snd_wnd = r.peer_window;
            end
            if ((r.seg_flags & FLAG_RST) != 6'd0) begin
                conn_st = ST_CLOSED;
                p.drop_conn = 1'b1;
            end else begin
                case (conn_st)
                    ST_CLOSED: begin
                        p.send_action = ACT_RST;
                    end
                    ST_LISTEN: begin
                        if ((r.seg_flags & FLAG_SYN) == 6'd0) begin
                            p.send_action = ACT_RST;
                        end else begin
                            p.send_action = ACT_SPAWN;
                            spawned = 1'b1;
                        end
                    end
                    ST_SYN_SENT: begin
                        if ((r.seg_flags & FLAG_SYN) != 6'd0
                            && (r.seg_flags & FLAG_ACK) != 6'd0) begin
                            rcv_nxt = r.seg_seq_end;
                            snd_una = r.seg_ack;
                            snd_wnd = r.peer_window;
                            p.send_action = ACT_ACK;
                            conn_st = ST_ESTABLISHED;
                            p.wake_connect = 1'b1;
                        end else begin
                            p.send_action = ACT_RST;
                        end
                    end
                    ST_SYN_RECV: begin
                        snd_wnd = r.peer_window;
                        conn_st = ST_ESTABLISHED;
                        p.wake_accept = 1'b1;
                    end
                    ST_FIN_WAIT_1: begin
                        if (r.seg_ack == r.snd_next) begin
                            conn_st = ST_FIN_WAIT_2;
                        end
                    end
                    ST_FIN_WAIT_2: begin
                        if ((r.seg_flags & FLAG_FIN) != 6'd0 && r.seg_ack == r.snd_next) begin
                            conn_st = ST_TIME_WAIT;
                            p.start_timewait = 1'b1;
                            p.send_action = ACT_ACK;
                        end
                    end
                    ST_CLOSE_WAIT: begin
                        if ((r.seg_flags & FLAG_FIN) != 6'd0) begin
                            p.send_action = ACT_ACK;
                        end
                    end
                    ST_TIME_WAIT: begin
                        if (r.seg_flags == (FLAG_FIN | FLAG_ACK)) begin
                            p.send_action = ACT_ACK;
                        end
                    end
                    ST_LAST_ACK: begin
                        if (r.seg_flags == FLAG_ACK && r.seg_ack == r.snd_next) begin
                            conn_st = ST_CLOSED;
                        end
                    end
                    ST_ESTABLISHED: begin
                        if ((r.seg_flags & FLAG_FIN) != 6'd0 && r.seg_ack == r.snd_next) begin
                            conn_st = ST_CLOSE_WAIT;
                            p.send_action = ACT_ACK;
                        end else if (r.payload_len != 16'd0) begin
                            p.deliver_payload = 1'b1;
                            p.send_action = ACT_ACK;
                        end else if (r.seg_flags == FLAG_ACK) begin
                            p.send_action = ACT_NONE;
                        end else begin
                            p.send_action = ACT_ACK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        p.conn_state_out  = conn_st;
        p.rcv_next_out    = spawned ? r.seg_seq_end : rcv_nxt;
        p.snd_unack_out   = snd_una;
        p.send_window_out = snd_wnd;
        return p;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            conn_st = ST_CLOSED;
            rcv_nxt = 32'd0;
            snd_una = 32'd0;
            snd_wnd = 16'd0;
            expected_q.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_q.push_back(predict_result(i_req.data));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (expected_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("send_action",
                                32'(want.send_action), 32'(got.send_action));
                    check_field("conn_state_out",
                                32'(want.conn_state_out), 32'(got.conn_state_out));
                    check_field("rcv_next_out", want.rcv_next_out, got.rcv_next_out);
                    check_field("snd_unack_out", want.snd_unack_out, got.snd_unack_out);
                    check_field("send_window_out",
                                32'(want.send_window_out), 32'(got.send_window_out));
                    check_field("deliver_payload",
                                32'(want.deliver_payload), 32'(got.deliver_payload));
                    check_field("in_order", 32'(want.in_order), 32'(got.in_order));
                    check_field("wake_send", 32'(want.wake_send), 32'(got.wake_send));
                    check_field("wake_connect",
                                32'(want.wake_connect), 32'(got.wake_connect));
                    check_field("wake_accept",
                                32'(want.wake_accept), 32'(got.wake_accept));
                    check_field("start_timewait",
                                32'(want.start_timewait), 32'(got.start_timewait));
                    check_field("drop_conn", 32'(want.drop_conn), 32'(got.drop_conn));
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/tb_tcp_receive_state_machine.sv]
// Testbench top for the TCP receive state machine: clock, reset, stimulus and verdict.
module tb_tcp_receive_state_machine;
    timeunit 1ns;
    timeprecision 1ps;

    import trsm_pkg::*;

    // The push flag is not in the package; it only matters to the rules with an exact flag
    // compare (established, last ack, time wait), so it is handy for building data segments.
    localparam logic [5:0] FLAG_PSH = 6'h08;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int items_sent = 0;

    // Sequence space as the generator sees it: flow_seq follows the peer's byte stream,
    // tx_next follows our own transmit side. Keeping segments on flow_seq makes most of
    // them land in order, which is what lets the connection reach its deeper states.
    logic [31:0] flow_seq;
    logic [31:0] tx_next;

    trsm_req_if req_ch ();
    trsm_rsp_if rsp_ch ();

    tcp_receive_state_machine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    trsm_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle length used by both sides: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A request with every field random; this is the noise that reaches every bit.
    function automatic t_req rand_item();
        t_req r;
        r.req_type    = 1'($urandom);
        r.new_state   = 4'($urandom);
        r.seg_flags   = 6'($urandom);
        r.seg_seq     = $urandom;
        r.seg_seq_end = $urandom;
        r.seg_ack     = $urandom;
        r.peer_window = 16'($urandom);
        r.payload_len = 16'($urandom);
        r.snd_next    = $urandom;
        r.init_seq    = $urandom;
        return r;
    endfunction

    // A local command; the segment fields are left random since the block must ignore them.
    function automatic t_req make_cmd(input logic [3:0] st);
        t_req r;
        r = rand_item();
        r.req_type  = REQ_COMMAND;
        r.new_state = st;
        return r;
    endfunction

    // A segment that continues the peer's stream. With exact_ack the ack matches our
    // send-next, which the closing transitions require; otherwise the ack is sometimes
    // behind (still inside the window) and sometimes ahead (outside it).
    function automatic t_req flow_seg(input logic [5:0] flags, input logic [15:0] len,
                                      input bit exact_ack);
        t_req r;
        int   pick;
        r = rand_item();
        r.req_type    = REQ_SEGMENT;
        r.seg_flags   = flags;
        r.payload_len = len;
        r.seg_seq     = flow_seq;
        r.seg_seq_end = flow_seq + 32'(len) + 32'((flags & FLAG_SYN) != 6'd0)
                        + 32'((flags & FLAG_FIN) != 6'd0);
        if ($urandom_range(0, 1) == 1) tx_next = tx_next + $urandom_range(1, 1500);
        r.snd_next = tx_next;
        pick = $urandom_range(0, 9);
        if (exact_ack || pick < 6) begin
            r.seg_ack = tx_next;
        end else if (pick < 8) begin
            r.seg_ack = tx_next - $urandom_range(1, 3000);
        end else begin
            r.seg_ack = tx_next + $urandom_range(1, 3000);
        end
        // A zero window now and then, so that a later segment reopens it.
        r.peer_window = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom);
        flow_seq = r.seg_seq_end;
        return r;
    endfunction

    // Payload sizes: mostly typical, some empty, a few anywhere in the 16-bit range.
    function automatic logic [15:0] pick_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return 16'd0;
        if (roll < 9) return 16'($urandom_range(1, 1500));
        return 16'($urandom);
    endfunction

    // Offers one request and holds it until the block takes it. After the transaction the
    // sender may idle; two stretches run without any idling, the first of them overlapping
    // the long hold-off on the result side so that the block fills and stalls its input.
    task automatic send_item(input t_req item);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        gap = pick_gap();
        if ((items_sent >= 300 && items_sent < 420) || (items_sent >= 550 && items_sent < 620)) begin
            gap = 0;
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Start a fresh stream; some streams sit just below the wrap point of the sequence space.
    task automatic new_flow();
        flow_seq = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
        tx_next  = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
    endtask

    // Data transfer in the established state: in-order data, bare ACKs, segments with
    // odd flags, the occasional out-of-order segment and the occasional reset.
    task automatic exchange_data();
        t_req        item;
        logic [31:0] saved;
        int          roll;
        repeat ($urandom_range(1, 8)) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                send_item(flow_seg(FLAG_ACK | FLAG_PSH, pick_len(), 1'b0));
            end else if (roll < 78) begin
                send_item(flow_seg(FLAG_ACK, 16'd0, 1'b0));
            end else if (roll < 88) begin
                send_item(flow_seg(6'($urandom) & ~(FLAG_FIN | FLAG_RST), pick_len(), 1'b0));
            end else if (roll < 96) begin
                saved = flow_seq;
                item = flow_seg(FLAG_ACK | FLAG_PSH, pick_len(), 1'b0);
                item.seg_seq = item.seg_seq + $urandom_range(1, 5000);
                flow_seq = saved;
                send_item(item);
            end else begin
                send_item(flow_seg(FLAG_RST | FLAG_ACK, 16'd0, 1'b0));
            end
        end
    endtask

    // Ends a connection: a passive close, an active close, or an abort by reset.
    task automatic close_conn();
        t_req item;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
            if ($urandom_range(0, 2) == 0) send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
            send_item(make_cmd(ST_LAST_ACK));
            if ($urandom_range(0, 2) == 0) begin
                item = flow_seg(FLAG_ACK, 16'd0, 1'b1);
                item.seg_ack = item.snd_next + 32'd1;
                send_item(item);
            end
            send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));
        end else if (roll < 85) begin
            send_item(make_cmd(ST_FIN_WAIT_1));
            if ($urandom_range(0, 2) == 0) send_item(flow_seg(FLAG_ACK, pick_len(), 1'b0));
            send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));
            if ($urandom_range(0, 3) == 0) send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b0));
            send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
            repeat ($urandom_range(0, 2)) send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b0));
        end else begin
            send_item(flow_seg(FLAG_RST, 16'd0, 1'b0));
        end
    endtask

    // One random scenario. Most are complete connection lifetimes with random content;
    // the rest are a forced state followed by loose segments, or pure noise.
    task automatic run_session();
        int roll;
        roll = $urandom_range(0, 99);
        new_flow();
        if (roll < 25) begin
            // Active open, sometimes with a broken handshake first.
            send_item(make_cmd(ST_SYN_SENT));
            if ($urandom_range(0, 3) == 0) send_item(flow_seg(FLAG_SYN, 16'd0, 1'b1));
            send_item(flow_seg(FLAG_SYN | FLAG_ACK, 16'd0, 1'b1));
            exchange_data();
            close_conn();
        end else if (roll < 45) begin
            // Passive open: the listener spawns a child, which then takes the final ACK.
            send_item(make_cmd(ST_LISTEN));
            if ($urandom_range(0, 3) == 0) send_item(flow_seg(FLAG_ACK, 16'd0, 1'b0));
            send_item(flow_seg(FLAG_SYN, 16'd0, 1'b1));
            send_item(make_cmd(ST_SYN_RECV));
            send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));
            exchange_data();
            close_conn();
        end else if (roll < 65) begin
            send_item(make_cmd(ST_ESTABLISHED));
            exchange_data();
            close_conn();
        end else if (roll < 80) begin
            send_item(make_cmd(4'($urandom_range(0, 10))));
            repeat ($urandom_range(1, 4)) begin
                send_item(flow_seg(6'($urandom), pick_len(), 1'($urandom)));
            end
        end else begin
            repeat ($urandom_range(1, 4)) send_item(rand_item());
        end
    endtask

    // Result side: ready in random bursts with random stalls. Once, after a few hundred
    // transactions, it holds off for a long stretch while the sender keeps offering.
    initial begin
        int  run_len;
        int  stall;
        bit  pressure_done;
        pressure_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!pressure_done && items_sent >= 300) begin
                rsp_ch.ready <= 1'b0;
                repeat (80) @(posedge i_clk);
                pressure_done = 1'b1;
            end else begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 12);
                rsp_ch.ready <= 1'b1;
                repeat (run_len) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        t_req item;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Closed, every field zero: rcv_next is unknown and stays zero, a reset is sent back.
        item = '0;
        item.req_type = REQ_SEGMENT;
        send_item(item);
        // Every field at its maximum, reset flag included: the connection is dropped, the
        // unknown rcv_next is taken from the segment and the zero window reopens.
        item = '1;
        item.req_type = REQ_SEGMENT;
        send_item(item);
        // A command for a state outside the encoding is ignored.
        send_item(make_cmd(4'hF));

        // Listener: a segment without SYN is refused, a SYN spawns a child.
        flow_seq = 32'h0000_1000;
        tx_next  = 32'h0000_5000;
        send_item(make_cmd(ST_LISTEN));
        send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_SYN, 16'd0, 1'b1));
        send_item(make_cmd(ST_SYN_RECV));
        send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));

        // Established: data, a bare ACK with a closed window, a flag-only segment, then
        // the peer's FIN into close wait, where a repeated FIN is acknowledged.
        send_item(flow_seg(FLAG_ACK | FLAG_PSH, 16'd100, 1'b1));
        item = flow_seg(FLAG_ACK, 16'd0, 1'b1);
        item.peer_window = 16'd0;
        send_item(item);
        send_item(flow_seg(FLAG_PSH, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));

        // Last ACK: a stale ack keeps the state, the matching one closes.
        send_item(make_cmd(ST_LAST_ACK));
        item = flow_seg(FLAG_ACK, 16'd0, 1'b1);
        item.seg_ack = item.snd_next - 32'd1;
        send_item(item);
        send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));

        // Active open: a lone SYN is refused, SYN with ACK completes it.
        send_item(make_cmd(ST_SYN_SENT));
        send_item(flow_seg(FLAG_SYN, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_SYN | FLAG_ACK, 16'd0, 1'b1));

        // Active close: an ack beyond send-next is outside the window and leaves the state and
        // window as they are, the matching ack moves on, the FIN starts time wait, and a
        // retransmitted FIN|ACK there is acknowledged again.
        send_item(make_cmd(ST_FIN_WAIT_1));
        item = flow_seg(FLAG_ACK, 16'd0, 1'b1);
        item.seg_ack = item.snd_next + 32'h10;
        send_item(item);
        send_item(flow_seg(FLAG_ACK, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));
        send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));

        // Closing only does the common bookkeeping.
        send_item(make_cmd(ST_CLOSING));
        send_item(flow_seg(FLAG_FIN | FLAG_ACK, 16'd0, 1'b1));

        while (items_sent < 775) run_session();
        req_ch.valid <= 1'b0;

        // The checker's count of outstanding results is registered, so let it account for the
        // last transaction before waiting for it to drain.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
